// File: design/dan_pkg.sv
// Shared types, weights and divider constants for the duration accumulate/normalize block
package dan_pkg;

	// Operation classes decoded from the opcode field
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_CMP  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	// One signed calendar duration
	typedef struct packed {
		logic               neg;
		logic signed [15:0] weeks;
		logic signed [15:0] days;
		logic signed [15:0] hours;
		logic signed [15:0] minutes;
		logic signed [15:0] seconds;
	} dur_t;

	// One queued transaction
	typedef struct packed {
		op_t  op;
		dur_t dur;
	} entry_t;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Field weights in seconds
	localparam int WEIGHT_WEEK   = 604800;
	localparam int WEIGHT_DAY    = 86400;
	localparam int WEIGHT_HOUR   = 3600;
	localparam int WEIGHT_MINUTE = 60;

	// Exact totals fit in 37 signed bits (five weighted 16-bit fields, then negation)
	localparam int TOT_W = 37;

	// Reciprocal shifts: each covers the largest dividend of its step
	localparam int WEEK_SHIFT = 32;
	localparam int DAY_SHIFT  = 32;
	localparam int HOUR_SHIFT = 17;
	localparam int MIN_SHIFT  = 12;

	// Truncated reciprocals; quotient estimate is low by at most one
	localparam longint RECIP_WEEK = (64'd1 << WEEK_SHIFT) / WEIGHT_WEEK;
	localparam longint RECIP_DAY  = (64'd1 << DAY_SHIFT) / WEIGHT_DAY;
	localparam longint RECIP_HOUR = (64'd1 << HOUR_SHIFT) / WEIGHT_HOUR;
	localparam longint RECIP_MIN  = (64'd1 << MIN_SHIFT) / WEIGHT_MINUTE;

	// Compare result codes
	localparam logic signed [1:0] CMP_LT = -2'sd1;
	localparam logic signed [1:0] CMP_EQ = 2'sd0;
	localparam logic signed [1:0] CMP_GT = 2'sd1;

	// One weighted term of an exact total
	function automatic logic signed [TOT_W-1:0] weigh(input logic signed [15:0] v,
		input int w);
		logic signed [TOT_W-1:0] ext_v;
		logic signed [TOT_W-1:0] ext_w;
		ext_v = TOT_W'(v);
		ext_w = TOT_W'(w);
		return ext_v * ext_w;
	endfunction

	// True when an exact total does not fit 32-bit signed
	function automatic logic out_of_range(input logic signed [TOT_W-1:0] t);
		return !((&t[TOT_W-1:31]) || !(|t[TOT_W-1:31]));
	endfunction

endpackage

// File: design/dan_req_if.sv
// Input channel: opcode plus one signed duration
interface dan_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic               in_negative;
	logic signed [15:0] in_weeks;
	logic signed [15:0] in_days;
	logic signed [15:0] in_hours;
	logic signed [15:0] in_minutes;
	logic signed [15:0] in_seconds;

	modport source (
		output valid, opcode, in_negative, in_weeks, in_days, in_hours, in_minutes,
			in_seconds,
		input  ready
	);
	modport sink (
		input  valid, opcode, in_negative, in_weeks, in_days, in_hours, in_minutes,
			in_seconds,
		output ready
	);
endinterface

// File: design/dan_rsp_if.sv
// Result channel: stored duration, its total, compare result and overflow
interface dan_rsp_if;
	logic               valid;
	logic               ready;
	logic               out_negative;
	logic signed [15:0] out_weeks;
	logic signed [15:0] out_days;
	logic signed [15:0] out_hours;
	logic signed [15:0] out_minutes;
	logic signed [15:0] out_seconds;
	logic signed [31:0] total_seconds;
	logic signed [1:0]  compare_result;
	logic               overflow;

	modport source (
		output valid, out_negative, out_weeks, out_days, out_hours, out_minutes,
			out_seconds, total_seconds, compare_result, overflow,
		input  ready
	);
	modport sink (
		input  valid, out_negative, out_weeks, out_days, out_hours, out_minutes,
			out_seconds, total_seconds, compare_result, overflow,
		output ready
	);
endinterface

// File: design/dan_front.sv
// Front end: accepts transactions, decodes the opcode and stages them for the queue
module dan_front (
	input  logic              clk,
	input  logic              arst_n,
	dan_req_if.sink           req,
	output logic              push_valid,
	output dan_pkg::entry_t   push_data,
	input  logic              push_ready
);

	dan_pkg::entry_t ent_s1;
	logic            ent_valid_s1;
	dan_pkg::op_t    op_dec;
	logic            req_fire;

	// Stage slot is free when empty or draining into the queue this cycle
	assign req.ready  = !ent_valid_s1 || push_ready;
	assign req_fire   = req.valid && req.ready;
	assign push_valid = ent_valid_s1;
	assign push_data  = ent_s1;

	// Opcode decode
	always_comb begin
		case (req.opcode)
			dan_pkg::OP_LOAD: op_dec = dan_pkg::OP_LOAD;
			dan_pkg::OP_ADD:  op_dec = dan_pkg::OP_ADD;
			dan_pkg::OP_CMP:  op_dec = dan_pkg::OP_CMP;
			default:          op_dec = dan_pkg::OP_NOP;
		endcase
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_s1 <= 1'b0;
		end else if (req_fire) begin
			ent_valid_s1 <= 1'b1;
		end else if (push_ready) begin
			ent_valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ent_s1.op          <= op_dec;
			ent_s1.dur.neg     <= req.in_negative;
			ent_s1.dur.weeks   <= req.in_weeks;
			ent_s1.dur.days    <= req.in_days;
			ent_s1.dur.hours   <= req.in_hours;
			ent_s1.dur.minutes <= req.in_minutes;
			ent_s1.dur.seconds <= req.in_seconds;
		end
	end

endmodule

// File: design/dan_queue.sv
// Short queue of decoded transactions between front and back
module dan_queue #(
	parameter int DEPTH = dan_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  dan_pkg::entry_t push_data,
	output logic            push_ready,
	output logic            head_valid,
	output dan_pkg::entry_t head,
	input  logic            pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	dan_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pull;

	assign push_ready = (count_q != FULL);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pull       = pop && head_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pull) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pull) begin
				count_q <= count_q + 1'b1;
			end else if (pull && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Fill count stays within depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL)
		else $error("queue count beyond depth");

	// Pop only takes an entry that is there
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head_valid) |=> $stable(rd_ptr_q))
		else $error("queue read pointer moved on empty pop");

endmodule

// File: design/dan_back.sv
// Back end: sequencer for load, add with normalize, compare, and the result register
module dan_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  dan_pkg::entry_t head,
	output logic            pop,
	dan_rsp_if.source       rsp
);

	localparam int TW = dan_pkg::TOT_W;

	typedef enum logic [3:0] {
		S_FIELDS, S_PROD, S_SUM, S_SIGN, S_CMP,
		S_D1, S_D2, S_D3, S_H1, S_H2, S_H3, S_M1, S_M2, S_M3,
		S_DONE
	} st_t;

	st_t st_q;

	// Stored duration and result register
	dan_pkg::dur_t     dur_q;
	dan_pkg::dur_t     out_q;
	logic signed [31:0] out_total_q;
	logic signed [1:0]  out_cmp_q;
	logic               out_ovf_q;
	logic               rsp_valid_q;

	// Datapath registers
	dan_pkg::dur_t       fld_q;
	logic signed [TW-1:0] pa_q [5];
	logic signed [TW-1:0] pb_q [5];
	logic signed [TW-1:0] ta_q;
	logic signed [TW-1:0] tb_q;
	logic                 ovf_q;
	logic signed [1:0]    cmp_q;
	logic [31:0]          mag_q;
	logic [12:0]          qw_q;
	logic [15:0]          qd_q;
	logic [20:0]          rw_q;
	logic [17:0]          rd_q;
	logic                 wk_hit_q;
	logic [4:0]           qh_q;
	logic [12:0]          rh_q;
	logic [5:0]           qm_q;
	logic [6:0]           rm_q;

	dan_pkg::dur_t        fld_d;
	dan_pkg::dur_t        norm_d;
	dan_pkg::dur_t        new_dur;
	logic [44:0]          pw;
	logic [47:0]          pd;
	logic [22:0]          ph;
	logic [17:0]          pm;
	logic signed [31:0]   wa;
	logic signed [31:0]   wb;
	logic                 out_load;

	assign out_load = (st_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign pop      = out_load;

	// Fields that the operation works on
	always_comb begin
		case (head.op)
			dan_pkg::OP_LOAD: begin
				fld_d = head.dur;
			end
			dan_pkg::OP_ADD: begin
				fld_d.neg = dur_q.neg;
				if (head.dur.neg == dur_q.neg) begin
					fld_d.weeks   = dur_q.weeks + head.dur.weeks;
					fld_d.days    = dur_q.days + head.dur.days;
					fld_d.hours   = dur_q.hours + head.dur.hours;
					fld_d.minutes = dur_q.minutes + head.dur.minutes;
					fld_d.seconds = dur_q.seconds + head.dur.seconds;
				end else begin
					fld_d.weeks   = dur_q.weeks - head.dur.weeks;
					fld_d.days    = dur_q.days - head.dur.days;
					fld_d.hours   = dur_q.hours - head.dur.hours;
					fld_d.minutes = dur_q.minutes - head.dur.minutes;
					fld_d.seconds = dur_q.seconds - head.dur.seconds;
				end
			end
			default: begin
				fld_d = dur_q;
			end
		endcase
	end

	// Reciprocal products of the divider steps
	assign pw = 45'(mag_q) * 45'(dan_pkg::RECIP_WEEK);
	assign pd = 48'(mag_q) * 48'(dan_pkg::RECIP_DAY);
	assign ph = 23'(rd_q) * 23'(dan_pkg::RECIP_HOUR);
	assign pm = 18'(rh_q) * 18'(dan_pkg::RECIP_MIN);

	assign wa = ta_q[31:0];
	assign wb = tb_q[31:0];

	// Normalized duration: whole weeks alone, else days/hours/minutes/seconds
	always_comb begin
		norm_d.neg     = ta_q[31];
		norm_d.weeks   = wk_hit_q ? 16'(qw_q) : 16'sd0;
		norm_d.days    = wk_hit_q ? 16'sd0 : 16'(qd_q);
		norm_d.hours   = 16'(qh_q);
		norm_d.minutes = 16'(qm_q);
		norm_d.seconds = 16'(rm_q);
	end

	assign new_dur = (head.op == dan_pkg::OP_ADD) ? norm_d : fld_q;

	// Sequencer state, stored duration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_FIELDS;
			dur_q       <= '0;
			out_q       <= '0;
			out_total_q <= '0;
			out_cmp_q   <= dan_pkg::CMP_EQ;
			out_ovf_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				S_FIELDS: if (head_valid) st_q <= S_PROD;
				S_PROD:   st_q <= S_SUM;
				S_SUM:    st_q <= S_SIGN;
				S_SIGN:   st_q <= S_CMP;
				S_CMP:    st_q <= (head.op == dan_pkg::OP_ADD) ? S_D1 : S_DONE;
				S_D1:     st_q <= S_D2;
				S_D2:     st_q <= S_D3;
				S_D3:     st_q <= S_H1;
				S_H1:     st_q <= S_H2;
				S_H2:     st_q <= S_H3;
				S_H3:     st_q <= S_M1;
				S_M1:     st_q <= S_M2;
				S_M2:     st_q <= S_M3;
				S_M3:     st_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						st_q        <= S_FIELDS;
						dur_q       <= new_dur;
						out_q       <= new_dur;
						out_total_q <= wa;
						out_cmp_q   <= cmp_q;
						out_ovf_q   <= ovf_q;
					end
				end
				default:  st_q <= S_FIELDS;
			endcase
		end
	end

	// Datapath: weighted totals, then constant dividers for normalize
	always_ff @(posedge clk) begin
		case (st_q)
			S_FIELDS: begin
				fld_q <= fld_d;
			end
			S_PROD: begin
				pa_q[0] <= dan_pkg::weigh(fld_q.weeks, dan_pkg::WEIGHT_WEEK);
				pa_q[1] <= dan_pkg::weigh(fld_q.days, dan_pkg::WEIGHT_DAY);
				pa_q[2] <= dan_pkg::weigh(fld_q.hours, dan_pkg::WEIGHT_HOUR);
				pa_q[3] <= dan_pkg::weigh(fld_q.minutes, dan_pkg::WEIGHT_MINUTE);
				pa_q[4] <= TW'(fld_q.seconds);
				pb_q[0] <= dan_pkg::weigh(head.dur.weeks, dan_pkg::WEIGHT_WEEK);
				pb_q[1] <= dan_pkg::weigh(head.dur.days, dan_pkg::WEIGHT_DAY);
				pb_q[2] <= dan_pkg::weigh(head.dur.hours, dan_pkg::WEIGHT_HOUR);
				pb_q[3] <= dan_pkg::weigh(head.dur.minutes, dan_pkg::WEIGHT_MINUTE);
				pb_q[4] <= TW'(head.dur.seconds);
			end
			S_SUM: begin
				ta_q <= pa_q[0] + pa_q[1] + pa_q[2] + pa_q[3] + pa_q[4];
				tb_q <= pb_q[0] + pb_q[1] + pb_q[2] + pb_q[3] + pb_q[4];
			end
			S_SIGN: begin
				ta_q <= fld_q.neg ? -ta_q : ta_q;
				tb_q <= head.dur.neg ? -tb_q : tb_q;
			end
			S_CMP: begin
				// Compare wrapped totals; overflow per operation
				if (head.op == dan_pkg::OP_CMP) begin
					ovf_q <= dan_pkg::out_of_range(ta_q) || dan_pkg::out_of_range(tb_q);
					cmp_q <= (wa < wb) ? dan_pkg::CMP_LT :
						((wa > wb) ? dan_pkg::CMP_GT : dan_pkg::CMP_EQ);
				end else begin
					ovf_q <= dan_pkg::out_of_range(ta_q);
					cmp_q <= dan_pkg::CMP_EQ;
				end
				// Magnitude of the wrapped total; the most negative value maps to 2^31
				mag_q <= wa[31] ? (~32'(wa) + 32'd1) : 32'(wa);
			end
			S_D1: begin
				qw_q <= pw[44:32];
				qd_q <= pd[47:32];
			end
			S_D2: begin
				rw_q <= 21'(mag_q - 32'(qw_q) * 32'(dan_pkg::WEIGHT_WEEK));
				rd_q <= 18'(mag_q - 32'(qd_q) * 32'(dan_pkg::WEIGHT_DAY));
			end
			S_D3: begin
				// Estimates are low by at most one
				if (rw_q >= 21'(dan_pkg::WEIGHT_WEEK)) begin
					qw_q     <= qw_q + 13'd1;
					wk_hit_q <= (rw_q == 21'(dan_pkg::WEIGHT_WEEK));
				end else begin
					wk_hit_q <= (rw_q == '0);
				end
				if (rd_q >= 18'(dan_pkg::WEIGHT_DAY)) begin
					qd_q <= qd_q + 16'd1;
					rd_q <= rd_q - 18'(dan_pkg::WEIGHT_DAY);
				end
			end
			S_H1: begin
				qh_q <= 5'(ph >> dan_pkg::HOUR_SHIFT);
			end
			S_H2: begin
				rh_q <= 13'(rd_q - 18'(qh_q) * 18'(dan_pkg::WEIGHT_HOUR));
			end
			S_H3: begin
				if (rh_q >= 13'(dan_pkg::WEIGHT_HOUR)) begin
					qh_q <= qh_q + 5'd1;
					rh_q <= rh_q - 13'(dan_pkg::WEIGHT_HOUR);
				end
			end
			S_M1: begin
				qm_q <= 6'(pm >> dan_pkg::MIN_SHIFT);
			end
			S_M2: begin
				rm_q <= 7'(rh_q - 13'(qm_q) * 13'(dan_pkg::WEIGHT_MINUTE));
			end
			S_M3: begin
				if (rm_q >= 7'(dan_pkg::WEIGHT_MINUTE)) begin
					qm_q <= qm_q + 6'd1;
					rm_q <= rm_q - 7'(dan_pkg::WEIGHT_MINUTE);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.out_negative   = out_q.neg;
	assign rsp.out_weeks      = out_q.weeks;
	assign rsp.out_days       = out_q.days;
	assign rsp.out_hours      = out_q.hours;
	assign rsp.out_minutes    = out_q.minutes;
	assign rsp.out_seconds    = out_q.seconds;
	assign rsp.total_seconds  = out_total_q;
	assign rsp.compare_result = out_cmp_q;
	assign rsp.overflow       = out_ovf_q;

	// Sequencer waits for work when the queue is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIELDS && !head_valid) |=> st_q == S_FIELDS)
		else $error("sequencer started without a queued transaction");

	// An entry leaves the queue only when its result is registered
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (st_q == S_DONE && head_valid))
		else $error("queue popped outside result write");

	// A normalized add leaves hours, minutes and seconds in their ranges
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && head.op == dan_pkg::OP_ADD) |=>
		(dur_q.hours >= 0 && dur_q.hours < 24 && dur_q.minutes >= 0 &&
		dur_q.minutes < 60 && dur_q.seconds >= 0 && dur_q.seconds < 60))
		else $error("normalized fields out of range");

endmodule

// File: design/duration_accumulate_normalize.sv
// Path from input to result: the front stage register, the queue, then the back sequencer,
// whose first state reads the queue head; add also runs the divider states after compare.
// The back sequencer works one transaction at a time; the front keeps accepting while the
// queue has room.
// Reset (arst_n low, asynchronous): stored duration cleared to zero, queue emptied,
// no result pending.
module duration_accumulate_normalize #(
	parameter int QUEUE_DEPTH = dan_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	dan_req_if.sink   req,
	dan_rsp_if.source rsp
);

	logic            push_valid;
	logic            push_ready;
	dan_pkg::entry_t push_data;
	logic            head_valid;
	dan_pkg::entry_t head;
	logic            pop;

	// Accept and decode
	dan_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// Decoupling queue
	dan_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Execute and report
	dan_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
